### design/kwc_pkg.sv
// Shared constants, codes and request types of the window chain table.
package kwc_pkg;

    localparam int WINDOW_SLOTS = 1024;
    localparam int KEY_BUCKETS  = 256;
    localparam int RETIRE_AHEAD = 292;

    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int KEY_W  = $clog2(KEY_BUCKETS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int BACK_W = $clog2(KEY_BUCKETS + WINDOW_SLOTS + 1) + 1;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 10;
    localparam int BYTE_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_RETIRE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UL_RD,
        ST_UL_WR,
        ST_HD_RD,
        ST_HD_WR,
        ST_LK_WR
    } t_state;

    typedef struct packed {
        logic              we;
        logic [KEY_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic [KEY_W-1:0]  raddr;
    } t_head_req;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_next_req;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [BACK_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_back_req;

endpackage

### design/kwc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/kwc_ctrl.sv
// Command sequencer: clear sweep, unlink and head insert over the link memories.
module kwc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [kwc_pkg::CMD_W-1:0]     i_command,
    input  logic [kwc_pkg::POS_W-1:0]     i_position,
    input  logic [kwc_pkg::BYTE_W-1:0]    i_byte_value,
    input  logic                          i_end_of_input,
    input  logic [kwc_pkg::LINK_W-1:0]    i_head_rdata,
    input  logic [kwc_pkg::LINK_W-1:0]    i_next_rdata,
    input  logic [kwc_pkg::BACK_W-1:0]    i_back_rdata,
    output kwc_pkg::t_head_req            o_head_req,
    output kwc_pkg::t_next_req            o_next_req,
    output kwc_pkg::t_back_req            o_back_req,
    output logic                          o_valid,
    output logic                          o_previous_valid,
    output logic [kwc_pkg::POS_W-1:0]     o_previous_slot,
    output logic                          o_inserted
);

    kwc_pkg::t_state              r_state, n_state;
    logic [kwc_pkg::SLOT_W-1:0]   r_clr, n_clr;
    logic                         r_report, n_report;
    logic [kwc_pkg::SLOT_W-1:0]   r_target, n_target;
    logic [kwc_pkg::SLOT_W-1:0]   r_pos, n_pos;
    logic [kwc_pkg::KEY_W-1:0]    r_key, n_key;
    logic                         r_last, n_last;
    logic [kwc_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [kwc_pkg::LINK_W-1:0]   r_old, n_old;
    logic                         r_valid, n_valid;
    logic                         r_prev_valid, n_prev_valid;
    logic [kwc_pkg::POS_W-1:0]    r_prev_slot, n_prev_slot;
    logic                         r_inserted, n_inserted;

    logic [kwc_pkg::SLOT_W:0]     ahead_sum;
    logic [kwc_pkg::SLOT_W-1:0]   ahead;
    logic [kwc_pkg::SLOT_W-1:0]   in_pos;
    logic [kwc_pkg::BACK_W-1:0]   link_slot;
    logic [kwc_pkg::LINK_W-1:0]   fwd_idx;
    logic [kwc_pkg::LINK_W-1:0]   old_idx;

    assign in_pos    = i_position[kwc_pkg::SLOT_W-1:0];
    assign ahead_sum = {1'b0, in_pos} + (kwc_pkg::SLOT_W+1)'(kwc_pkg::RETIRE_AHEAD);
    assign ahead     = (ahead_sum >= (kwc_pkg::SLOT_W+1)'(kwc_pkg::WINDOW_SLOTS))
                     ? kwc_pkg::SLOT_W'(ahead_sum - (kwc_pkg::SLOT_W+1)'(kwc_pkg::WINDOW_SLOTS))
                     : ahead_sum[kwc_pkg::SLOT_W-1:0];
    assign link_slot = i_back_rdata - kwc_pkg::BACK_W'(kwc_pkg::KEY_BUCKETS + 1);
    assign fwd_idx   = i_next_rdata - kwc_pkg::LINK_W'(1);
    assign old_idx   = r_old - kwc_pkg::LINK_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kwc_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_report <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_report <= n_report;
            r_valid  <= n_valid;
        end
        r_target     <= n_target;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_last       <= n_last;
        r_cmd        <= n_cmd;
        r_old        <= n_old;
        r_prev_valid <= n_prev_valid;
        r_prev_slot  <= n_prev_slot;
        r_inserted   <= n_inserted;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_report     = r_report;
        n_target     = r_target;
        n_pos        = r_pos;
        n_key        = r_key;
        n_last       = r_last;
        n_cmd        = r_cmd;
        n_old        = r_old;
        n_valid      = 1'b0;
        n_prev_valid = r_prev_valid;
        n_prev_slot  = r_prev_slot;
        n_inserted   = r_inserted;

        o_head_req       = '0;
        o_head_req.raddr = r_key;
        o_next_req       = '0;
        o_next_req.raddr = r_target;
        o_back_req       = '0;
        o_back_req.raddr = r_target;

        unique case (r_state)
            kwc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_pos  = in_pos;
                    n_key  = i_byte_value;
                    n_last = i_end_of_input;
                    n_cmd  = i_command;
                    unique case (kwc_pkg::t_cmd'(i_command))
                        kwc_pkg::CMD_CLEAR: begin
                            n_state  = kwc_pkg::ST_CLEAR;
                            n_clr    = '0;
                            n_report = 1'b1;
                        end
                        kwc_pkg::CMD_BYTE: begin
                            n_target = ahead;
                            n_state  = kwc_pkg::ST_UL_RD;
                        end
                        kwc_pkg::CMD_RETIRE: begin
                            n_target = in_pos;
                            n_state  = kwc_pkg::ST_UL_RD;
                        end
                        default: begin
                            n_valid      = 1'b1;
                            n_prev_valid = 1'b0;
                            n_prev_slot  = '0;
                            n_inserted   = 1'b0;
                        end
                    endcase
                end
            end
            kwc_pkg::ST_CLEAR: begin
                o_back_req.we    = 1'b1;
                o_back_req.waddr = r_clr;
                o_back_req.wdata = '0;
                o_head_req.we    = 1'b1;
                o_head_req.waddr = r_clr[kwc_pkg::KEY_W-1:0];
                o_head_req.wdata = '0;
                if (r_clr == kwc_pkg::SLOT_W'(kwc_pkg::WINDOW_SLOTS - 1)) begin
                    n_state      = kwc_pkg::ST_IDLE;
                    n_valid      = r_report;
                    n_prev_valid = 1'b0;
                    n_prev_slot  = '0;
                    n_inserted   = 1'b0;
                end else begin
                    n_clr = r_clr + kwc_pkg::SLOT_W'(1);
                end
            end
            kwc_pkg::ST_UL_RD: begin
                n_state = kwc_pkg::ST_UL_WR;
            end
            kwc_pkg::ST_UL_WR: begin
                if (i_back_rdata != '0) begin
                    if (i_next_rdata != '0 &&
                        fwd_idx < kwc_pkg::LINK_W'(kwc_pkg::WINDOW_SLOTS)) begin
                        o_back_req.we    = 1'b1;
                        o_back_req.waddr = fwd_idx[kwc_pkg::SLOT_W-1:0];
                        o_back_req.wdata = i_back_rdata;
                    end
                    if (i_back_rdata <= kwc_pkg::BACK_W'(kwc_pkg::KEY_BUCKETS)) begin
                        o_head_req.we    = 1'b1;
                        o_head_req.waddr = kwc_pkg::KEY_W'(i_back_rdata - kwc_pkg::BACK_W'(1));
                        o_head_req.wdata = i_next_rdata;
                    end else if (link_slot < kwc_pkg::BACK_W'(kwc_pkg::WINDOW_SLOTS)) begin
                        o_next_req.we    = 1'b1;
                        o_next_req.waddr = link_slot[kwc_pkg::SLOT_W-1:0];
                        o_next_req.wdata = i_next_rdata;
                    end
                end
                if (r_cmd == kwc_pkg::CMD_BYTE && !r_last) begin
                    n_state = kwc_pkg::ST_HD_RD;
                end else begin
                    n_state      = kwc_pkg::ST_IDLE;
                    n_valid      = 1'b1;
                    n_prev_valid = 1'b0;
                    n_prev_slot  = '0;
                    n_inserted   = 1'b0;
                end
            end
            kwc_pkg::ST_HD_RD: begin
                n_state = kwc_pkg::ST_HD_WR;
            end
            kwc_pkg::ST_HD_WR: begin
                n_old            = i_head_rdata;
                o_next_req.we    = 1'b1;
                o_next_req.waddr = r_pos;
                o_next_req.wdata = i_head_rdata;
                o_back_req.we    = 1'b1;
                o_back_req.waddr = r_pos;
                o_back_req.wdata = kwc_pkg::BACK_W'(r_key) + kwc_pkg::BACK_W'(1);
                o_head_req.we    = 1'b1;
                o_head_req.waddr = r_key;
                o_head_req.wdata = kwc_pkg::LINK_W'(r_pos) + kwc_pkg::LINK_W'(1);
                if (i_head_rdata != '0 &&
                    (i_head_rdata - kwc_pkg::LINK_W'(1)) <
                    kwc_pkg::LINK_W'(kwc_pkg::WINDOW_SLOTS)) begin
                    n_state = kwc_pkg::ST_LK_WR;
                end else begin
                    n_state      = kwc_pkg::ST_IDLE;
                    n_valid      = 1'b1;
                    n_prev_valid = 1'b0;
                    n_prev_slot  = '0;
                    n_inserted   = 1'b1;
                end
            end
            kwc_pkg::ST_LK_WR: begin
                o_back_req.we    = 1'b1;
                o_back_req.waddr = old_idx[kwc_pkg::SLOT_W-1:0];
                o_back_req.wdata = kwc_pkg::BACK_W'(kwc_pkg::KEY_BUCKETS + 1)
                                 + kwc_pkg::BACK_W'(r_pos);
                n_state      = kwc_pkg::ST_IDLE;
                n_valid      = 1'b1;
                n_prev_valid = 1'b1;
                n_prev_slot  = kwc_pkg::POS_W'(old_idx[kwc_pkg::SLOT_W-1:0]);
                n_inserted   = 1'b1;
            end
            default: begin
                n_state = kwc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy           = (r_state != kwc_pkg::ST_IDLE);
    assign o_valid          = r_valid;
    assign o_previous_valid = r_prev_valid;
    assign o_previous_slot  = r_prev_slot;
    assign o_inserted       = r_inserted;

    a_link_has_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kwc_pkg::ST_LK_WR |-> r_old != '0)
        else $error("back link write without an old head");

    a_insert_after_unlink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kwc_pkg::ST_HD_RD |-> $past(r_state) == kwc_pkg::ST_UL_WR)
        else $error("head read did not follow an unlink");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kwc_pkg::ST_CLEAR && r_clr != '0 |-> !r_valid)
        else $error("result during clear sweep");

endmodule

### design/byte_keyed_window_chain_table.sv
// Top level of the byte-keyed window chain table: sequencer and link memories.
//
// channel   direction  handshake                  payload
// command   in         start / busy               i_command, i_position, i_byte_value,
//                                                 i_end_of_input
// result    out        o_valid (one-cycle strobe) o_previous_valid, o_previous_slot,
//                                                 o_inserted
//
// A byte command runs the unlink read-modify-write on the link memories, then, unless it ends
// the input, the head insert (and a back-link write for an old head). A retire only unlinks.
// A clear command walks all 1024 back-link entries, one per cycle.
// After reset the same clearing pass runs with busy high; it gives no result.
// Results are strobed for one cycle and cannot be held off.
module byte_keyed_window_chain_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [kwc_pkg::CMD_W-1:0]  i_command,
    input  logic [kwc_pkg::POS_W-1:0]  i_position,
    input  logic [kwc_pkg::BYTE_W-1:0] i_byte_value,
    input  logic                       i_end_of_input,
    output logic                       o_valid,
    output logic                       o_previous_valid,
    output logic [kwc_pkg::POS_W-1:0]  o_previous_slot,
    output logic                       o_inserted
);

    kwc_pkg::t_head_req            head_req;
    kwc_pkg::t_next_req            next_req;
    kwc_pkg::t_back_req            back_req;
    logic [kwc_pkg::LINK_W-1:0]    head_rdata;
    logic [kwc_pkg::LINK_W-1:0]    next_rdata;
    logic [kwc_pkg::BACK_W-1:0]    back_rdata;

    kwc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_byte_value     (i_byte_value),
        .i_end_of_input   (i_end_of_input),
        .i_head_rdata     (head_rdata),
        .i_next_rdata     (next_rdata),
        .i_back_rdata     (back_rdata),
        .o_head_req       (head_req),
        .o_next_req       (next_req),
        .o_back_req       (back_req),
        .o_valid          (o_valid),
        .o_previous_valid (o_previous_valid),
        .o_previous_slot  (o_previous_slot),
        .o_inserted       (o_inserted)
    );

    kwc_ram #(.WIDTH(kwc_pkg::LINK_W), .DEPTH(kwc_pkg::KEY_BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_req.we),
        .i_waddr (head_req.waddr),
        .i_wdata (head_req.wdata),
        .i_raddr (head_req.raddr),
        .o_rdata (head_rdata)
    );

    kwc_ram #(.WIDTH(kwc_pkg::LINK_W), .DEPTH(kwc_pkg::WINDOW_SLOTS)) u_next (
        .i_clk   (i_clk),
        .i_we    (next_req.we),
        .i_waddr (next_req.waddr),
        .i_wdata (next_req.wdata),
        .i_raddr (next_req.raddr),
        .o_rdata (next_rdata)
    );

    kwc_ram #(.WIDTH(kwc_pkg::BACK_W), .DEPTH(kwc_pkg::WINDOW_SLOTS)) u_back (
        .i_clk   (i_clk),
        .i_we    (back_req.we),
        .i_waddr (back_req.waddr),
        .i_wdata (back_req.wdata),
        .i_raddr (back_req.raddr),
        .o_rdata (back_rdata)
    );

    a_byte_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == kwc_pkg::CMD_BYTE |=> busy)
        else $error("byte command did not start the sequencer");

    a_prev_needs_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_inserted |-> !o_previous_valid && o_previous_slot == '0)
        else $error("previous slot reported without an insert");

    a_no_insert_on_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == kwc_pkg::CMD_RETIRE |=> !o_valid)
        else $error("retire produced an early result");

endmodule
